// ----- src/assert_macros.svh -----
// Assertion helper macros shared by the allocator RTL.
// Compiled to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fba assertion failed");

// next-cycle implication
`define FBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fba assertion failed");

`else

`define FBA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FBA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/fba_pkg.sv -----
// Shared types and constants for the frame bitmap allocator.
// No dependencies.
`timescale 1ns / 1ps

package fba_pkg;

   localparam int FRAME_W              = 15;
   localparam int WORD_W               = 32;
   localparam int BIT_W                = 5;
   localparam int WORD_IDX_W           = FRAME_W - BIT_W;
   localparam int DEFAULT_BITMAP_WORDS = 1024;

   typedef enum logic [1:0] {
      OP_ALLOC     = 2'd0,
      OP_MARK_FREE = 2'd1,
      OP_MARK_USED = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

endpackage

// ----- src/fba_mem.sv -----
// Bitmap word store: one write port, one registered read port.
// Depends on fba_pkg for the word width.
`timescale 1ns / 1ps

module fba_mem #(
   parameter int DEPTH = fba_pkg::DEFAULT_BITMAP_WORDS,
   parameter int AW    = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [fba_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [fba_pkg::WORD_W-1:0] rd_data
);

   logic [fba_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/fba_lsb.sv -----
// Lowest-set-bit finder for one bitmap word: index and one-hot mask.
// Depends on fba_pkg for widths.
`timescale 1ns / 1ps

module fba_lsb (
   input  logic [fba_pkg::WORD_W-1:0] word,
   output logic [fba_pkg::BIT_W-1:0]  index,
   output logic [fba_pkg::WORD_W-1:0] onehot
);

   localparam int WW = fba_pkg::WORD_W;
   localparam int BW = fba_pkg::BIT_W;

   always_comb begin
      onehot = word & (~word + WW'(1));
      index  = '0;
      for (int b = 0; b < WW; b++) begin
         if (onehot[b]) begin
            index = index | BW'(b);
         end
      end
   end

endmodule

// ----- src/frame_bitmap_allocator_top.sv -----
// Frame bitmap allocator: one availability bit per page frame, 32 frames per word.
// Usage:
//   req_ channel carries one transaction: operation, frame_number, claim.
//   rsp_ channel returns exactly one transaction per request: found_frame,
//   status, is_available.
//   A request is taken when req_valid is high and req_stall low; the block
//   holds req_stall high while it works on a request, so one is in flight.
// Sequence:
//   mark / query: read the word (ST_FETCH), update or test it (ST_MODIFY),
//   then load the output (ST_RESP); a frame beyond the bitmap goes to ST_RESP.
//   allocate: scans one bitmap word per cycle through the single read port,
//   then picks the first nonzero word (ST_PICK) and loads the output (ST_RESP).
// Requests do not overlap: the next request can be taken in the cycle in
//   which rsp_valid rises.
// Reset (synchronous, active high) starts a clearing pass that writes zero
//   into every word, one per cycle, with req_stall high throughout.
// Receiver stall: the result sits in the output register until taken; the
//   next request may be accepted meanwhile and its result waits internally.
// Depends on fba_pkg, fba_mem, fba_lsb and assert_macros.svh.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top #(
   parameter int BITMAP_WORDS = fba_pkg::DEFAULT_BITMAP_WORDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [fba_pkg::FRAME_W-1:0] req_frame_number,
   input  logic                        req_claim,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fba_pkg::FRAME_W-1:0] rsp_found_frame,
   output logic                        rsp_status,
   output logic                        rsp_is_available
);

   `include "assert_macros.svh"

   localparam int FW = fba_pkg::FRAME_W;
   localparam int WW = fba_pkg::WORD_W;
   localparam int BW = fba_pkg::BIT_W;
   localparam int XW = fba_pkg::WORD_IDX_W;
   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_SCAN,
      ST_PICK,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   fba_pkg::op_type   op_ff, op_in;
   logic [XW-1:0]     word_ff, word_in;
   logic [BW-1:0]     bit_ff, bit_in;
   logic              claim_ff, claim_in;
   logic [AW-1:0]     scan_addr_ff, scan_addr_in;
   logic              issued_all_ff, issued_all_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [AW-1:0]     chk_addr_ff, chk_addr_in;
   logic [AW-1:0]     hit_addr_ff, hit_addr_in;
   logic [WW-1:0]     hit_word_ff, hit_word_in;
   logic [FW-1:0]     res_found_ff, res_found_in;
   logic              res_status_ff, res_status_in;
   logic              res_avail_ff, res_avail_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]     rsp_found_ff, rsp_found_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_avail_ff, rsp_avail_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WW-1:0]     mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [WW-1:0]     mem_rdata;

   logic [BW-1:0]     lsb_index;
   logic [WW-1:0]     lsb_onehot;

   logic [XW-1:0]     req_word;
   logic              req_in_range;
   logic [AW-1:0]     word_addr;
   logic [WW-1:0]     bit_mask;
   logic [AW+BW-1:0]  pick_frame;

   fba_mem #(
      .DEPTH (BITMAP_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   fba_lsb u_lsb (
      .word   (hit_word_ff),
      .index  (lsb_index),
      .onehot (lsb_onehot)
   );

   assign req_word     = req_frame_number[FW-1:BW];
   assign req_in_range = (32'(req_word) < BITMAP_WORDS);
   assign word_addr    = AW'(word_ff);
   assign bit_mask     = WW'(1) << bit_ff;
   assign pick_frame   = {hit_addr_ff, lsb_index};

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found_frame  = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_available = rsp_avail_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      claim_in      = claim_ff;
      scan_addr_in  = scan_addr_ff;
      issued_all_in = issued_all_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      hit_addr_in   = hit_addr_ff;
      hit_word_in   = hit_word_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      res_avail_in  = res_avail_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_avail_in  = rsp_avail_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_addr_ff;
      mem_wdata     = '0;
      mem_raddr     = scan_addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_addr_ff;
            if (scan_addr_ff == LAST_ADDR) begin
               scan_addr_in = '0;
               state_in     = ST_IDLE;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = fba_pkg::op_type'(req_operation);
               word_in       = req_word;
               bit_in        = req_frame_number[BW-1:0];
               claim_in      = req_claim;
               res_found_in  = '0;
               res_status_in = 1'b0;
               res_avail_in  = 1'b0;
               if (fba_pkg::op_type'(req_operation) == fba_pkg::OP_ALLOC) begin
                  scan_addr_in  = '0;
                  issued_all_in = 1'b0;
                  chk_valid_in  = 1'b0;
                  state_in      = ST_SCAN;
               end else if (req_in_range) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_FETCH: begin
            mem_raddr = word_addr;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            mem_waddr = word_addr;
            case (op_ff)
               fba_pkg::OP_MARK_FREE: begin
                  mem_we    = 1'b1;
                  mem_wdata = mem_rdata | bit_mask;
               end
               fba_pkg::OP_MARK_USED: begin
                  mem_we    = 1'b1;
                  mem_wdata = mem_rdata & ~bit_mask;
               end
               fba_pkg::OP_QUERY: begin
                  res_avail_in = mem_rdata[bit_ff];
               end
               default: begin
               end
            endcase
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            mem_raddr    = scan_addr_ff;
            chk_valid_in = !issued_all_ff;
            chk_addr_in  = scan_addr_ff;
            if (!issued_all_ff) begin
               if (scan_addr_ff == LAST_ADDR) begin
                  issued_all_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (chk_valid_ff && (mem_rdata != '0)) begin
               hit_addr_in = chk_addr_ff;
               hit_word_in = mem_rdata;
               state_in    = ST_PICK;
            end else if (chk_valid_ff && (chk_addr_ff == LAST_ADDR)) begin
               res_status_in = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_PICK: begin
            res_found_in = FW'(pick_frame);
            mem_waddr    = hit_addr_ff;
            mem_wdata    = hit_word_ff & ~lsb_onehot;
            mem_we       = claim_ff;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_avail_in  = res_avail_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      claim_ff      <= claim_in;
      chk_addr_ff   <= chk_addr_in;
      hit_addr_ff   <= hit_addr_in;
      hit_word_ff   <= hit_word_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      res_avail_ff  <= res_avail_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_avail_ff  <= rsp_avail_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_addr_ff  <= '0;
         issued_all_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         issued_all_ff <= issued_all_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `FBA_ASSERT_IMP(a_fail_frame_zero, clock, reset, rsp_valid && rsp_status, (rsp_found_frame == '0) && !rsp_is_available)
   `FBA_ASSERT_IMP(a_pick_nonzero, clock, reset, state_ff == ST_PICK, hit_word_ff != '0)
   `FBA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `FBA_ASSERT_IMP(a_load_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RESP)

endmodule
